// ===== sv/sck_pkg.sv =====
// shared types and constants for the sph cubic spline kernel
`default_nettype none
package sck_pkg;

   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 8;
   localparam int QUOT_W    = 33;
   localparam int DIV_STEPS = 33;

   // divide by three through a reciprocal: floor(2^36 / 3)
   localparam int             RECIP3_SHIFT = 36;
   localparam logic [35:0]    RECIP3       = 36'd22906492245;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_H = 8'd0,
      CSR_NORM  = 8'd1
   } sck_csr_idx_type;

   // request handed from the kernel math to the gradient divider
   typedef struct packed {
      logic                    valid;
      logic [DATA_W-1:0]       w;
      logic [2:0][63:0]        num;
      logic [DATA_W-1:0]       den;
      logic [2:0]              pos;
      logic                    zero_grad;
   } sck_grad_req_type;

endpackage
`default_nettype wire

// ===== sv/sck_if.sv =====
// request, response and register write channels
`default_nettype none
interface sck_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sep_x;
   logic [31:0] sep_y;
   logic [31:0] sep_z;
   logic [31:0] distance;
   modport source (output valid, sep_x, sep_y, sep_z, distance, input ready);
   modport sink   (input valid, sep_x, sep_y, sep_z, distance, output ready);
endinterface

interface sck_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] kernel_value;
   logic [31:0] grad_x;
   logic [31:0] grad_y;
   logic [31:0] grad_z;
   modport source (output valid, kernel_value, grad_x, grad_y, grad_z, input ready);
   modport sink   (input valid, kernel_value, grad_x, grad_y, grad_z, output ready);
endinterface

interface sck_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/sck_div_lane.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module sck_div_lane (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [63:0]                 num,
   input  wire logic [31:0]                 den,
   output logic [sck_pkg::QUOT_W-1:0]       quot,
   output logic                             ovf
);
   localparam int N = sck_pkg::DIV_STEPS;

   logic [31:0]                 rem_ff  [0:N];
   logic [32:0]                 low_ff  [0:N];
   logic [sck_pkg::QUOT_W-1:0]  quot_ff [0:N];
   logic [31:0]                 den_ff  [0:N];
   logic                        ovf_ff  [0:N];

   // entry: quotient of 2^33 or more is flagged and saturated later
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= {1'b0, num[63:33]};
         low_ff[0]  <= num[32:0];
         quot_ff[0] <= '0;
         den_ff[0]  <= den;
         ovf_ff[0]  <= {1'b0, num[63:33]} >= den;
      end
   end

   // one restoring step per stage
   for (genvar k = 1; k <= N; k++) begin : g_step
      logic [32:0] trial;
      logic        ge;
      assign trial = {rem_ff[k-1], low_ff[k-1][32]};
      assign ge    = trial >= {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? 32'(trial - {1'b0, den_ff[k-1]}) : trial[31:0];
            low_ff[k]  <= {low_ff[k-1][31:0], 1'b0};
            quot_ff[k] <= {quot_ff[k-1][sck_pkg::QUOT_W-2:0], ge};
            den_ff[k]  <= den_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
         end
      end
   end

   assign quot = quot_ff[N];
   assign ovf  = ovf_ff[N];
endmodule
`default_nettype wire

// ===== sv/sck_kernel_calc.sv =====
// kernel math pipeline: q, region, polynomials, scaling and gradient numerators
`default_nettype none
module sck_kernel_calc #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [31:0]               sep_x,
   input  wire logic [31:0]               sep_y,
   input  wire logic [31:0]               sep_z,
   input  wire logic [31:0]               distance,
   input  wire logic [31:0]               inv_h,
   input  wire logic [31:0]               norm,
   output sck_pkg::sck_grad_req_type      grad_req
);
   localparam int QW = FRAC_BITS + 2;
   localparam int MW = FRAC_BITS + 3;
   localparam int SW = 2 * QW;
   localparam int PW = QW + MW;
   localparam int CW = 2 * QW;
   localparam int NS = 7;
   localparam logic [QW-1:0] ONE_Q      = QW'(1) << FRAC_BITS;
   localparam logic [QW-1:0] TWO_Q      = QW'(2) << FRAC_BITS;
   localparam logic [MW-1:0] FOUR_Q     = MW'(4) << FRAC_BITS;
   localparam logic [QW-1:0] TWO_THIRDS = QW'(((64'd2 << FRAC_BITS) + 64'd1) / 64'd3);
   localparam logic [63:0]   Q_LIMIT    = 64'd2 << (2 * FRAC_BITS);

   typedef struct packed {
      logic [2:0][31:0] dmag;
      logic [2:0]       pos;
      logic             zero_grad;
      logic [31:0]      r;
      logic             inner;
      logic             outside;
   } side_type;

   logic [NS:1]  v_ff;
   side_type     side_ff [1:NS];
   side_type     side_in;
   logic [31:0]  sep [0:2];

   logic [63:0]           p_ff;
   logic [QW-1:0]         a_ff, a2_ff, m_ff, y_ff, qe_ff, poly_in_ff, poly_ff;
   logic [SW-1:0]         sq_ff;
   logic [PW-1:0]         mp_ff;
   logic [CW-1:0]         cube_ff;
   logic [63:0]           pm_full_ff, w_full_ff;
   logic [65:0]           pmul_ff;
   logic [31:0]           pmag_ff;
   sck_pkg::sck_grad_req_type out_ff;

   assign sep[0] = sep_x;
   assign sep[1] = sep_y;
   assign sep[2] = sep_z;

   // separation magnitudes and signs
   always_comb begin
      side_in = '0;
      for (int c = 0; c < 3; c++) begin
         side_in.pos[c]  = sep[c][31];
         side_in.dmag[c] = sep[c][31] ? 32'(~sep[c] + 32'd1) : sep[c];
      end
      side_in.zero_grad = (distance == 32'd0);
      side_in.r         = distance;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-1:1], in_valid};
      end
   end

   // stage 1: exact product r * (1/h)
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff       <= 64'(distance) * 64'(inv_h);
         side_ff[1] <= side_in;
      end
   end

   // stage 2: region select, base squared and derivative product
   logic [QW-1:0] q2_q, a2_a;
   logic [MW-1:0] mfac;
   logic          inner2, outside2;
   side_type      side2_in;
   always_comb begin
      q2_q     = p_ff[FRAC_BITS +: QW];
      outside2 = p_ff >= Q_LIMIT;
      inner2   = q2_q < ONE_Q;
      a2_a     = inner2 ? q2_q : QW'(TWO_Q - q2_q);
      mfac     = inner2 ? MW'(FOUR_Q - MW'(3) * MW'(q2_q)) : MW'(a2_a);
      side2_in         = side_ff[1];
      side2_in.inner   = inner2;
      side2_in.outside = outside2;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff       <= a2_a;
         sq_ff      <= SW'(a2_a) * SW'(a2_a);
         mp_ff      <= PW'(a2_a) * PW'(mfac);
         side_ff[2] <= side2_in;
      end
   end

   // stage 3: cube and derivative factor
   logic [QW-1:0] a2_s3;
   assign a2_s3 = sq_ff[FRAC_BITS +: QW];
   always_ff @(posedge clock) begin
      if (en) begin
         a2_ff      <= a2_s3;
         cube_ff    <= CW'(a2_s3) * CW'(a_ff);
         m_ff       <= side_ff[2].inner ? mp_ff[FRAC_BITS + 1 +: QW]
                                        : sq_ff[FRAC_BITS + 1 +: QW];
         side_ff[3] <= side_ff[2];
      end
   end

   // stage 4: polynomial candidates and alpha * m
   logic [QW:0]    a3, pos_sum;
   logic [QW-1:0]  y4;
   logic [QW+35:0] qe_full;
   always_comb begin
      a3      = cube_ff[FRAC_BITS +: QW + 1];
      y4      = a3[QW:1];
      qe_full = (QW + 36)'(y4) * (QW + 36)'(sck_pkg::RECIP3);
      pos_sum = (QW + 1)'(TWO_THIRDS) + (QW + 1)'(y4);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         y_ff       <= y4;
         qe_ff      <= qe_full[sck_pkg::RECIP3_SHIFT +: QW];
         poly_in_ff <= (pos_sum > (QW + 1)'(a2_ff)) ? QW'(pos_sum - (QW + 1)'(a2_ff)) : '0;
         pm_full_ff <= 64'(norm) * 64'(m_ff);
         side_ff[4] <= side_ff[3];
      end
   end

   // stage 5: divide-by-three correction and scaling by 1/h
   logic [QW+1:0] rem3;
   logic [QW-1:0] poly_out;
   always_comb begin
      rem3     = (QW + 2)'(y_ff) - (QW + 2)'(3) * (QW + 2)'(qe_ff);
      poly_out = (rem3 >= (QW + 2)'(3)) ? QW'(qe_ff + QW'(1)) : qe_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         poly_ff    <= side_ff[4].inner ? poly_in_ff : poly_out;
         pmul_ff    <= 66'(pm_full_ff[FRAC_BITS +: 34]) * 66'(inv_h);
         side_ff[5] <= side_ff[4];
      end
   end

   // stage 6: alpha * poly, derivative magnitude with saturation
   logic [65:0] pm_shift;
   assign pm_shift = pmul_ff >> FRAC_BITS;
   always_ff @(posedge clock) begin
      if (en) begin
         w_full_ff  <= 64'(norm) * 64'(poly_ff);
         pmag_ff    <= (|pm_shift[65:32]) ? 32'hFFFF_FFFF : pm_shift[31:0];
         side_ff[6] <= side_ff[5];
      end
   end

   // stage 7: kernel value and gradient numerators
   logic [63:0] w_shift;
   assign w_shift = w_full_ff >> FRAC_BITS;
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[7]       <= side_ff[6];
         out_ff.valid     <= v_ff[NS-1];
         out_ff.w         <= side_ff[6].outside ? 32'd0 :
                             ((|w_shift[63:32]) ? 32'hFFFF_FFFF : w_shift[31:0]);
         for (int c = 0; c < 3; c++) begin
            out_ff.num[c] <= 64'(pmag_ff) * 64'(side_ff[6].dmag[c]);
         end
         out_ff.den       <= side_ff[6].r;
         out_ff.pos       <= side_ff[6].pos;
         out_ff.zero_grad <= side_ff[6].zero_grad | side_ff[6].outside;
      end
   end

   always_comb begin
      grad_req       = out_ff;
      grad_req.valid = v_ff[NS];
   end
endmodule
`default_nettype wire

// ===== sv/sck_grad_unit.sv =====
// gradient division, saturation and output register
`default_nettype none
module sck_grad_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire sck_pkg::sck_grad_req_type grad_req,
   output logic                           out_valid,
   output logic [31:0]                    kernel_value,
   output logic [31:0]                    grad_x,
   output logic [31:0]                    grad_y,
   output logic [31:0]                    grad_z
);
   localparam int D = sck_pkg::DIV_STEPS;

   sck_pkg::sck_grad_req_type      meta_ff [0:D];
   logic [sck_pkg::QUOT_W-1:0]     quot [0:2];
   logic [2:0]                     ovf;
   logic [31:0]                    grad_in [0:2];
   logic [31:0]                    grad_ff [0:2];
   logic [31:0]                    w_ff;
   logic [2:0]                     pos_ff;
   logic                           out_valid_ff;

   // one divider per component
   for (genvar c = 0; c < 3; c++) begin : g_lane
      sck_div_lane u_lane (
         .clock (clock),
         .en    (en),
         .num   (grad_req.num[c]),
         .den   (grad_req.den),
         .quot  (quot[c]),
         .ovf   (ovf[c])
      );
   end

   // side data travels alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= D; k++) begin
            meta_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         meta_ff[0] <= grad_req;
         for (int k = 1; k <= D; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   // sign and saturation
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [sck_pkg::QUOT_W-1:0] mag;
         mag = ovf[c] ? '1 : quot[c];
         if (meta_ff[D].zero_grad) begin
            grad_in[c] = 32'd0;
         end else if (meta_ff[D].pos[c]) begin
            grad_in[c] = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
         end else begin
            grad_in[c] = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(~mag[31:0] + 32'd1);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= meta_ff[D].valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         w_ff   <= meta_ff[D].w;
         pos_ff <= meta_ff[D].pos & {3{~meta_ff[D].zero_grad}};
         for (int c = 0; c < 3; c++) begin
            grad_ff[c] <= grad_in[c];
         end
      end
   end

   assign out_valid    = out_valid_ff;
   assign kernel_value = w_ff;
   assign grad_x       = grad_ff[0];
   assign grad_y       = grad_ff[1];
   assign grad_z       = grad_ff[2];

   // a stalled result stays
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !en |=> out_valid_ff)
      else $error("result dropped under stall");
   // positive-direction x and y gradients never come out negative
   a_pos_sign: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && pos_ff[0] |-> !grad_ff[0][31])
      else $error("x gradient sign flipped");
   a_pos_sign_y: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && pos_ff[1] |-> !grad_ff[1][31])
      else $error("y gradient sign flipped");
   // nothing leaves right after reset
   a_reset: assert property (@(posedge clock) reset |=> !out_valid_ff)
      else $error("output valid after reset");
endmodule
`default_nettype wire

// ===== sv/sph_cubic_spline_kernel.sv =====
// top level of the sph cubic spline kernel with gradient
//
// Takes one particle pair per request (separation x/y/z and distance, fixed point with
// FRAC_BITS fraction bits) and returns the 3D cubic spline kernel value and its gradient.
// A new request is accepted every cycle unless response backpressure stalls the pipeline.
// Each passes seven kernel math stages (one multiplier step each), a 34-stage divider (an
// entry stage, then one quotient bit per stage; one lane per gradient component) and the
// output register. The user must write registers 1/h (index 0) and alpha (index 1) over
// the csr channel while no request is in flight; the block itself does not enforce it.
`default_nettype none
module sph_cubic_spline_kernel #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   sck_req_if.sink     req,
   sck_rsp_if.source   rsp,
   sck_csr_if.sink     csr
);
   logic [31:0]               inv_h_ff;
   logic [31:0]               norm_ff;
   logic                      adv;
   logic                      out_valid;
   sck_pkg::sck_grad_req_type grad_req;

   // register writes
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_h_ff <= 32'd65536;
         norm_ff  <= 32'd31291;
      end else if (csr.valid) begin
         if (csr.index == sck_pkg::CSR_INV_H) begin
            inv_h_ff <= csr.data;
         end else if (csr.index == sck_pkg::CSR_NORM) begin
            norm_ff <= csr.data;
         end
      end
   end

   // pipeline advances unless a result is waiting
   assign adv       = !out_valid || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = out_valid;

   sck_kernel_calc #(
      .FRAC_BITS (FRAC_BITS)
   ) u_calc (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req.valid),
      .sep_x    (req.sep_x),
      .sep_y    (req.sep_y),
      .sep_z    (req.sep_z),
      .distance (req.distance),
      .inv_h    (inv_h_ff),
      .norm     (norm_ff),
      .grad_req (grad_req)
   );

   sck_grad_unit u_grad (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .grad_req     (grad_req),
      .out_valid    (out_valid),
      .kernel_value (rsp.kernel_value),
      .grad_x       (rsp.grad_x),
      .grad_y       (rsp.grad_y),
      .grad_z       (rsp.grad_z)
   );
endmodule
`default_nettype wire

// ===== sim/sck_tb_if.sv =====
// stimulus and expected-result types for the testbench
`timescale 1ns / 1ps
// bundle of one request item as the stimulus queue holds it
package sck_tb_pkg;
   typedef struct packed {
      logic [31:0] sep_x;
      logic [31:0] sep_y;
      logic [31:0] sep_z;
      logic [31:0] distance;
   } pair_type;

   typedef struct packed {
      logic [31:0] kernel_value;
      logic [31:0] grad_x;
      logic [31:0] grad_y;
      logic [31:0] grad_z;
   } kernel_out_type;
endpackage

// ===== sim/sph_cubic_spline_kernel_test.sv =====
// testbench for the sph cubic spline kernel: streams pairs, predicts and checks every result
`timescale 1ns / 1ps
module sph_cubic_spline_kernel_test;
   localparam int FRAC = 16;
   localparam int LATENCY = 42;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sck_req_if req ();
   sck_rsp_if rsp ();
   sck_csr_if csr ();

   sph_cubic_spline_kernel #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always #2 clock = ~clock;

   // predictor register copies
   logic [31:0] inv_h_q = 32'd65536;
   logic [31:0] norm_q  = 32'd31291;

   sck_tb_pkg::pair_type       pair_queue[$];
   sck_tb_pkg::kernel_out_type kernel_queue[$];
   int mismatch_count = 0;
   int req_idle_pct = 12;
   int rsp_idle_pct = 55;

   // gradient component: -pmag * d / r with saturation
   function automatic logic [31:0] grad_component(logic [63:0] pmag, logic [31:0] d,
                                                   logic [63:0] r);
      logic        neg;
      logic [63:0] dmag;
      logic [63:0] mag;
      neg  = d[31];
      dmag = neg ? {32'd0, -d} : {32'd0, d};
      mag  = (pmag * dmag) / r;
      if (neg) begin
         if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
         return mag[31:0];
      end
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return -mag[31:0];
   endfunction

   // kernel value and gradient for one pair
   function automatic sck_tb_pkg::kernel_out_type spline_kernel(sck_tb_pkg::pair_type p);
      sck_tb_pkg::kernel_out_type o;
      logic [63:0] r, ih, al, prod, q, t, t2, t3, q2, q3, pos, poly, m, pm, pmag, w;
      r    = {32'd0, p.distance};
      ih   = {32'd0, inv_h_q};
      al   = {32'd0, norm_q};
      prod = r * ih;
      o    = '0;
      if (prod >= (64'd2 << (2 * FRAC))) return o;
      q = prod >> FRAC;
      if (q >= (64'd1 << FRAC)) begin
         t    = (64'd2 << FRAC) - q;
         t2   = (t * t) >> FRAC;
         t3   = (t2 * t) >> FRAC;
         poly = t3 / 6;
         m    = (t * t) >> (FRAC + 1);
      end else begin
         q2   = (q * q) >> FRAC;
         q3   = (q2 * q) >> FRAC;
         pos  = (((64'd2 << FRAC) + 1) / 3) + (q3 >> 1);
         poly = pos > q2 ? pos - q2 : 64'd0;
         m    = (q * ((64'd4 << FRAC) - 3 * q)) >> (FRAC + 1);
      end
      w    = (al * poly) >> FRAC;
      pm   = (al * m) >> FRAC;
      pmag = (pm * ih) >> FRAC;
      if (pmag > 64'hFFFF_FFFF) pmag = 64'hFFFF_FFFF;
      o.kernel_value = w > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : w[31:0];
      if (r != 0) begin
         o.grad_x = grad_component(pmag, p.sep_x, r);
         o.grad_y = grad_component(pmag, p.sep_y, r);
         o.grad_z = grad_component(pmag, p.sep_z, r);
      end
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (pair_queue.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            sck_tb_pkg::pair_type p;
            p = pair_queue.pop_front();
            kernel_queue.push_back(spline_kernel(p));
            req.valid    <= 1'b1;
            req.sep_x    <= p.sep_x;
            req.sep_y    <= p.sep_y;
            req.sep_z    <= p.sep_z;
            req.distance <= p.distance;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // response monitor and random backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (kernel_queue.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) $display("unexpected response %h", rsp.kernel_value);
            end else begin
               sck_tb_pkg::kernel_out_type e;
               e = kernel_queue.pop_front();
               if (e.kernel_value !== rsp.kernel_value || e.grad_x !== rsp.grad_x ||
                   e.grad_y !== rsp.grad_y || e.grad_z !== rsp.grad_z) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch exp w=%h g=%h %h %h got w=%h g=%h %h %h",
                              e.kernel_value, e.grad_x, e.grad_y, e.grad_z, rsp.kernel_value,
                              rsp.grad_x, rsp.grad_y, rsp.grad_z);
               end
            end
         end
         rsp.ready <= $urandom_range(99) >= rsp_idle_pct;
      end
   end

   // register write, only while idle
   task automatic write_csr(sck_pkg::sck_csr_idx_type idx, logic [31:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      if (idx == sck_pkg::CSR_INV_H) inv_h_q = value;
      else if (idx == sck_pkg::CSR_NORM) norm_q = value;
   endtask

   task automatic wait_drained();
      while (pair_queue.size() != 0 || req.valid || kernel_queue.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_sep();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h0004_0000);
         2: return -$urandom_range(32'h0004_0000);
         default: return {{16{1'b0}}, 16'($urandom)};
      endcase
   endfunction

   // distance mostly within support of current 1/h
   function automatic logic [31:0] rand_dist();
      logic [63:0] span;
      span = (64'd3 << (2 * FRAC)) / (inv_h_q == 0 ? 64'd1 : {32'd0, inv_h_q});
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      case ($urandom_range(9))
         0: return $urandom;
         1: return 32'd0;
         default: return $urandom_range(span[31:0]);
      endcase
   endfunction

   task automatic queue_random(int count);
      sck_tb_pkg::pair_type p;
      repeat (count) begin
         p.sep_x = rand_sep();
         p.sep_y = rand_sep();
         p.sep_z = rand_sep();
         p.distance = rand_dist();
         pair_queue.push_back(p);
      end
   endtask

   // stimulus phases
   initial begin
      sck_tb_pkg::pair_type p;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero distance, region edges, field extremes
      write_csr(sck_pkg::CSR_NORM, 32'd31291);
      begin
         logic [31:0] dists[10];
         logic [31:0] seps[4];
         dists = '{32'd0, 32'd1, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_8000,
                   32'h0001_FFFF, 32'h0002_0000, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0001_0001};
         seps  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0};
         for (int i = 0; i < 10; i++) begin
            p.sep_x = seps[i % 4];
            p.sep_y = seps[(i + 1) % 4];
            p.sep_z = seps[(i + 2) % 4];
            p.distance = dists[i];
            pair_queue.push_back(p);
         end
      end
      wait_drained();

      // saturation: huge alpha and 1/h with tiny distances
      write_csr(sck_pkg::CSR_INV_H, 32'hFFFF_FFFF);
      write_csr(sck_pkg::CSR_NORM, 32'hFFFF_FFFF);
      for (int i = 0; i < 6; i++) begin
         p.sep_x = i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         p.sep_y = 32'h0000_0001;
         p.sep_z = 32'hFFFF_FFFF;
         p.distance = 32'(i);
         pair_queue.push_back(p);
      end
      wait_drained();

      // zero inverse length and zero alpha
      write_csr(sck_pkg::CSR_INV_H, 32'd0);
      queue_random(5);
      wait_drained();
      write_csr(sck_pkg::CSR_NORM, 32'd0);
      write_csr(sck_pkg::CSR_INV_H, 32'd1);
      queue_random(5);
      wait_drained();

      // random phases with different settings and idling
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_csr(sck_pkg::CSR_INV_H, 32'd65536);
               write_csr(sck_pkg::CSR_NORM, 32'd31291);
            end
            1: begin
               write_csr(sck_pkg::CSR_INV_H, 32'h0004_0000);
               write_csr(sck_pkg::CSR_NORM, 32'h0100_0000);
            end
            2: begin
               write_csr(sck_pkg::CSR_INV_H, 32'h0000_4000);
               write_csr(sck_pkg::CSR_NORM, 32'd500);
            end
            3: begin
               write_csr(sck_pkg::CSR_INV_H, $urandom);
               write_csr(sck_pkg::CSR_NORM, $urandom);
            end
            4: begin
               write_csr(sck_pkg::CSR_INV_H, 32'hFFFF_FFFF);
               write_csr(sck_pkg::CSR_NORM, 32'd1);
            end
            default: begin
               write_csr(sck_pkg::CSR_INV_H, $urandom_range(32'h0010_0000, 1));
               write_csr(sck_pkg::CSR_NORM, $urandom_range(32'h0010_0000));
            end
         endcase
         req_idle_pct = ph < 2 ? 12 : (ph < 4 ? 55 : 0);
         rsp_idle_pct = ph < 2 ? 55 : (ph < 4 ? 12 : 0);
         queue_random(105);
         wait_drained();
      end

      if (mismatch_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   // overall time limit
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
